// ===== design/bltg_pkg.sv =====
// Shared types, constants and the sine table of the band-limited square tone generator.
package bltg_pkg;

  localparam int unsigned SAMPLE_RATE_HZ  = 44100;
  localparam int unsigned HARMONIC_TERMS  = 22;
  localparam int unsigned SINE_TABLE_SIZE = 4096;

  localparam int unsigned FREQ_W   = 21;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TERM_W   = 5;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned QIDX_W   = 11;
  localparam int unsigned SINE_W   = 15;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned MUL_W    = 34;
  localparam int unsigned ACC_W    = 36;

  localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(HARMONIC_TERMS - 1);

  localparam int unsigned QTR_SIZE    = SINE_TABLE_SIZE / 4;
  localparam int unsigned HALF_SIZE   = SINE_TABLE_SIZE / 2;
  localparam int unsigned QTR_ENTRIES = QTR_SIZE + 1;

  // phase -> table index: floor(p * SIZE / RATE) as an exact reciprocal multiply
  localparam int unsigned IDX_K     = 44;
  localparam int unsigned IDX_SHIFT = IDX_K - IDX_W;
  localparam logic [63:0] IDX_MUL   =
    ((64'd1 << IDX_K) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ);
  localparam int unsigned IDX_MUL_W = 29;
  localparam int unsigned IDX_PROD_W = PHASE_W + IDX_MUL_W;

  // tone_freq mod RATE: quotient by exact reciprocal multiply
  localparam int unsigned FQ_K      = 37;
  localparam logic [63:0] FQ_MUL    =
    ((64'd1 << FQ_K) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ);
  localparam int unsigned FQ_MUL_W  = 22;
  localparam int unsigned FQ_PROD_W = FREQ_W + FQ_MUL_W;
  localparam int unsigned FQ_QUOT_W = 6;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32767;

  // Q1.16 weights of the odd harmonics 1, 3, ..., 43
  localparam logic [WEIGHT_W-1:0] WEIGHT [HARMONIC_TERMS] = '{
    17'd65536, 17'd21845, 17'd13107, 17'd9362, 17'd7282, 17'd5958,
    17'd5041,  17'd4369,  17'd3855,  17'd3449, 17'd3121, 17'd2849,
    17'd2621,  17'd2427,  17'd2260,  17'd2114, 17'd1986, 17'd1872,
    17'd1771,  17'd1680,  17'd1598,  17'd1524
  };

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic signed [65:0] Q30_ONE = 66'sd1073741824;
  localparam logic [63:0] TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  typedef logic [SINE_W-1:0] qrom_t [QTR_ENTRIES];

  // Q30 Taylor series of sin through x^15, truncated terms, rounded to Q15 at 32767
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] scaled;
    logic signed [65:0] sum;
    x    = (a * TWO_PI_Q30) / SINE_TABLE_SIZE;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({2'b00, x});
    for (int k = 0; k < 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k & 1) == 0) begin
        sum = sum - $signed({2'b00, term});
      end else begin
        sum = sum + $signed({2'b00, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    scaled = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return scaled[SINE_W-1:0];
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t r;
    for (int i = 0; i < QTR_ENTRIES; i++) begin
      r[i] = quarter_sine(64'(i));
    end
    return r;
  endfunction

  localparam qrom_t QSINE_ROM = build_qrom();

  localparam logic REG_TONE_FREQ = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic              start;
    logic              issue;
    logic [TERM_W-1:0] term;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } status_t;

endpackage

// ===== design/bltg_ctrl.sv =====
// Sequencer: accepts a sample request, issues one harmonic term a cycle, loads the result.
module bltg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bltg_pkg::status_t status_i,
  output bltg_pkg::cmd_t    cmd_o
);

  bltg_pkg::state_e state_q, state_d;
  logic [bltg_pkg::TERM_W-1:0] term_q, term_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    case (state_q)
      bltg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bltg_pkg::ST_RUN;
          term_d  = '0;
        end
      end
      bltg_pkg::ST_RUN: begin
        if (term_q == bltg_pkg::LAST_TERM) begin
          state_d = bltg_pkg::ST_DRAIN;
        end else begin
          term_d = term_q + 1'b1;
        end
      end
      bltg_pkg::ST_DRAIN: begin
        if (status_i.pipe_empty && out_free) begin
          state_d = bltg_pkg::ST_IDLE;
        end
      end
      default: state_d = bltg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.term  = term_q;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      bltg_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      bltg_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
      end
      bltg_pkg::ST_DRAIN: begin
        if (status_i.pipe_empty && out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bltg_pkg::ST_IDLE;
      term_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/bltg_dp.sv =====
// Datapath: phase, per-harmonic index pipeline, sine ROM, weighting and accumulation.
module bltg_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bltg_pkg::cmd_t                      cmd_i,
  output bltg_pkg::status_t                   status_o,
  input  logic [bltg_pkg::FREQ_W-1:0]         freq_i,
  input  logic                                end_of_block_i,
  output logic signed [bltg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                end_of_block_out_o
);

  localparam int unsigned PW = bltg_pkg::PHASE_W;
  localparam logic [PW:0] RATE_EXT = (PW + 1)'(bltg_pkg::SAMPLE_RATE_HZ);

  logic [PW-1:0] phase_q, phase_d;
  logic [PW-1:0] freq_mod_q;
  logic [bltg_pkg::FQ_QUOT_W-1:0] fq_quot_q;
  logic [bltg_pkg::FQ_PROD_W-1:0] fq_prod;
  logic [bltg_pkg::FREQ_W-1:0] fq_sub;

  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] step_q, step_d;
  logic          eob_q;

  logic v1_q, v2_q, v3_q;
  logic [bltg_pkg::IDX_PROD_W-1:0] prod1_q;
  logic [bltg_pkg::TERM_W-1:0] t1_q, t2_q;
  logic [bltg_pkg::IDX_W-1:0] idx;
  logic [bltg_pkg::QIDX_W-1:0] idx_half, qidx;
  logic [bltg_pkg::IDX_W-1:0] mirror;
  logic [bltg_pkg::SINE_W-1:0] rom_q;
  logic neg2_q;
  logic signed [bltg_pkg::SAMPLE_W-1:0] sval;
  logic signed [bltg_pkg::MUL_W-1:0] mul3_q;
  logic signed [bltg_pkg::ACC_W-1:0] acc_q, acc_adj, acc_div;
  logic signed [bltg_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic eob_out_q;

  logic [PW:0] psum, two_ph, nsum;

  // tone_freq mod rate, two register stages
  assign fq_prod = bltg_pkg::FQ_PROD_W'(freq_i) *
                   bltg_pkg::FQ_PROD_W'(bltg_pkg::FQ_MUL[bltg_pkg::FQ_MUL_W-1:0]);
  assign fq_sub  = freq_i - bltg_pkg::FREQ_W'(bltg_pkg::FREQ_W'(fq_quot_q) *
                   bltg_pkg::FREQ_W'(bltg_pkg::SAMPLE_RATE_HZ));

  always_ff @(posedge clk_i) begin
    fq_quot_q  <= fq_prod[bltg_pkg::FQ_K +: bltg_pkg::FQ_QUOT_W];
    freq_mod_q <= fq_sub[PW-1:0];
  end

  // harmonic h+2 sits 2*phase further on, modulo one turn
  always_comb begin
    two_ph = {phase_q, 1'b0};
    step_d = (two_ph >= RATE_EXT) ? PW'(two_ph - RATE_EXT) : two_ph[PW-1:0];
    psum   = {1'b0, p_q} + {1'b0, step_q};
    p_d    = (psum >= RATE_EXT) ? PW'(psum - RATE_EXT) : psum[PW-1:0];
    nsum   = {1'b0, phase_q} + {1'b0, freq_mod_q};
    phase_d = (nsum >= RATE_EXT) ? PW'(nsum - RATE_EXT) : nsum[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        phase_q <= phase_d;
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      p_q    <= phase_q;
      step_q <= step_d;
      eob_q  <= end_of_block_i;
    end else if (cmd_i.issue) begin
      p_q <= p_d;
    end
    prod1_q <= bltg_pkg::IDX_PROD_W'(p_q) *
               bltg_pkg::IDX_PROD_W'(bltg_pkg::IDX_MUL[bltg_pkg::IDX_MUL_W-1:0]);
    t1_q    <= cmd_i.term;
  end

  // fold the full-wave index onto the stored quarter wave
  always_comb begin
    idx      = prod1_q[bltg_pkg::IDX_SHIFT +: bltg_pkg::IDX_W];
    idx_half = idx[bltg_pkg::QIDX_W-1:0];
    mirror   = bltg_pkg::IDX_W'(bltg_pkg::HALF_SIZE) - {1'b0, idx_half};
    qidx     = (idx_half > bltg_pkg::QIDX_W'(bltg_pkg::QTR_SIZE)) ?
               mirror[bltg_pkg::QIDX_W-1:0] : idx_half;
  end

  always_ff @(posedge clk_i) begin
    rom_q  <= bltg_pkg::QSINE_ROM[qidx];
    neg2_q <= idx[bltg_pkg::IDX_W-1];
    t2_q   <= t1_q;
  end

  assign sval = neg2_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_ff @(posedge clk_i) begin
    mul3_q <= sval * $signed({1'b0, bltg_pkg::WEIGHT[t2_q]});
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + bltg_pkg::ACC_W'(mul3_q);
    end
  end

  // divide by 2^16 toward zero, then saturate
  always_comb begin
    acc_adj = acc_q + (acc_q[bltg_pkg::ACC_W-1] ? bltg_pkg::ACC_W'(65535) : '0);
    acc_div = acc_adj >>> 16;
    if (acc_div > bltg_pkg::ACC_W'(bltg_pkg::SAT_MAX)) begin
      sample_d = bltg_pkg::SAT_MAX;
    end else if (acc_div < bltg_pkg::ACC_W'(bltg_pkg::SAT_MIN)) begin
      sample_d = bltg_pkg::SAT_MIN;
    end else begin
      sample_d = acc_div[bltg_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_q  <= sample_d;
      eob_out_q <= eob_q;
    end
  end

  assign status_o.pipe_empty = !(v1_q || v2_q || v3_q);
  assign sample_o            = sample_q;
  assign end_of_block_out_o  = eob_out_q;

endmodule

// ===== design/bandlimited_square_tone_gen_core.sv =====
// Band-limited square tone generator: register port, sequencer and datapath.
// Each request runs the harmonic terms through the pipeline; the result is offered after it drains.
// A new request is stalled until the sample is done: the 22 harmonic terms are issued one per
// cycle into the four-stage index/ROM/multiply/accumulate pipeline, which then drains.
// Reset: tone_freq and phase clear to zero; the sine table is constant, no fill pass.
module bandlimited_square_tone_gen_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 end_of_block_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bltg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 end_of_block_out_o
);

  logic [bltg_pkg::FREQ_W-1:0] tone_freq_q;
  logic cfg_wr;
  bltg_pkg::cmd_t    cmd;
  bltg_pkg::status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bltg_pkg::REG_TONE_FREQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_freq_q <= '0;
    end else if (cfg_wr) begin
      tone_freq_q <= pwdata[bltg_pkg::FREQ_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bltg_pkg::REG_TONE_FREQ) ?
                  32'(tone_freq_q) : 32'd0;

  bltg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bltg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .freq_i             (tone_freq_q),
    .end_of_block_i     (end_of_block_i),
    .sample_o           (sample_o),
    .end_of_block_out_o (end_of_block_out_o)
  );

endmodule
